### rtl/tgbc_pkg.sv
`default_nettype none

package tgbc_pkg;

	localparam int COORD_W    = 17;
	localparam int MAG_W      = 16;
	localparam int TS_W       = 9;
	localparam int DIV_LANES  = 4;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = MAG_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam int LANE_X0 = 0;
	localparam int LANE_X1 = 1;
	localparam int LANE_Y0 = 2;
	localparam int LANE_Y1 = 3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] CFG_GRID_COLS = 2'd0;
	localparam logic [1:0] CFG_GRID_ROWS = 2'd1;
	localparam logic [1:0] CFG_TILE_SIZE = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [TS_W-1:0] tsize_t;

	typedef struct packed {
		logic   start;
		tsize_t divisor;
	} div_ctl_t;

endpackage

`default_nettype wire

### rtl/tgbc_div.sv
`default_nettype none

module tgbc_div (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  tgbc_pkg::div_ctl_t                              ctl,
	input  tgbc_pkg::coord_t [tgbc_pkg::DIV_LANES-1:0]      dividend,
	output tgbc_pkg::coord_t [tgbc_pkg::DIV_LANES-1:0]      quotient,
	output logic                                            done
);
	import tgbc_pkg::*;

	logic                              busy_q;
	logic                              done_q;
	logic [DIV_CNT_W-1:0]              cnt_q;
	tsize_t                            div_q;
	logic [DIV_LANES-1:0]              neg_q;
	logic [DIV_LANES-1:0][MAG_W-1:0]   work_q;
	logic [DIV_LANES-1:0][MAG_W-1:0]   work_nxt;
	logic [DIV_LANES-1:0][TS_W-1:0]    rem_q;
	logic [DIV_LANES-1:0][TS_W-1:0]    rem_nxt;
	logic [DIV_LANES-1:0][MAG_W-1:0]   mag;

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			mag[l] = dividend[l][COORD_W-1] ? MAG_W'(-dividend[l]) : MAG_W'(dividend[l]);
		end
	end

	always_comb begin
		logic [TS_W:0]    trial;
		logic [TS_W-1:0]  rem;
		logic [MAG_W-1:0] work;
		trial = '0;
		for (int l = 0; l < DIV_LANES; l++) begin
			rem  = rem_q[l];
			work = work_q[l];
			for (int k = 0; k < DIV_STEPS; k++) begin
				trial = {rem, work[MAG_W-1]};
				work  = {work[MAG_W-2:0], 1'b0};
				if (trial >= {1'b0, div_q}) begin
					trial   = trial - {1'b0, div_q};
					work[0] = 1'b1;
				end
				rem = trial[TS_W-1:0];
			end
			rem_nxt[l]  = rem;
			work_nxt[l] = work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= ctl.divisor;
			for (int l = 0; l < DIV_LANES; l++) begin
				neg_q[l]  <= dividend[l][COORD_W-1];
				work_q[l] <= mag[l];
				rem_q[l]  <= '0;
			end
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			quotient[l] = neg_q[l] ? -coord_t'(work_q[l]) : coord_t'(work_q[l]);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

### rtl/tgbc_tile_ram.sv
`default_nettype none

module tgbc_tile_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/tile_grid_box_collision.sv
`default_nettype none
// Items run from accept to out_valid: a write inside the grid, an ignored write, an empty box,
// a box reaching outside the grid, and a box inside it (N tiles read, one per cycle; stops at
// the first solid tile). Box coordinates are divided by the tile size before the grid check.
// One item at a time: the next word is taken once the result is queued.
// Reset: control and config registers take their reset values at once, then a clearing sweep
// writes all MAX_COLS * MAX_ROWS tile entries with in_stall high.
module tile_grid_box_collision #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [7:0]  tile_col,
	input  logic signed [7:0]  tile_row,
	input  logic [7:0]         tile_value,
	input  logic signed [15:0] box_x,
	input  logic signed [15:0] box_y,
	input  logic [11:0]        box_width,
	input  logic [11:0]        box_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic               write_ignored
);
	import tgbc_pkg::*;

	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DEC  = 4'd2;
	localparam logic [3:0] ST_WR   = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_CHK  = 4'd5;
	localparam logic [3:0] ST_WALK = 4'd6;
	localparam logic [3:0] ST_DONE = 4'd7;

	logic [3:0]         state_q;
	logic [3:0]         state_nxt;
	logic [AW-1:0]      clr_addr_q;
	logic [6:0]         grid_cols_q;
	logic [6:0]         grid_rows_q;
	tsize_t             tile_size_q;

	logic               func_q;
	logic signed [7:0]  tile_col_q;
	logic signed [7:0]  tile_row_q;
	logic [7:0]         tile_value_q;
	logic signed [15:0] box_x_q;
	logic signed [15:0] box_y_q;
	logic [11:0]        box_width_q;
	logic [11:0]        box_height_q;

	logic [AW-1:0]      base_q;
	logic [CW-1:0]      tx_q;
	logic [CW-1:0]      x0_q;
	logic [CW-1:0]      x1_q;
	logic [RW-1:0]      ty_q;
	logic [RW-1:0]      y1_q;
	logic               rd_pend_q;
	logic               last_q;
	logic               res_hit_q;
	logic               res_ign_q;
	logic               out_valid_q;
	logic               hit_q;
	logic               ign_q;

	logic [31:0]        cols_sat;
	logic [31:0]        rows_sat;
	logic [CW-1:0]      eff_cols;
	logic [RW-1:0]      eff_rows;
	coord_t             cols_c;
	coord_t             rows_c;
	tsize_t             ts_eff;
	coord_t             col_s;
	coord_t             row_s;
	logic               wr_out;
	logic               box_empty;

	div_ctl_t                     div_ctl;
	coord_t [DIV_LANES-1:0]       dividend;
	coord_t [DIV_LANES-1:0]       quotient;
	logic                         div_done;
	coord_t                       q_x0;
	coord_t                       q_x1;
	coord_t                       q_y0;
	coord_t                       q_y1;
	logic                         q_out;

	logic [RW-1:0]      mul_a;
	logic [RW+CW-1:0]   mul_full;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               rd_issue;
	logic               at_row_end;
	logic               at_end;
	logic               slot_free;
	logic               res_load;
	logic               res_hit_d;
	logic               res_ign_d;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_wdata;
	logic               ram_rdata;

	assign cols_sat = (32'(grid_cols_q) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(grid_cols_q);
	assign rows_sat = (32'(grid_rows_q) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(grid_rows_q);
	assign eff_cols = cols_sat[CW-1:0];
	assign eff_rows = rows_sat[RW-1:0];
	assign cols_c   = coord_t'(eff_cols);
	assign rows_c   = coord_t'(eff_rows);
	assign ts_eff   = (tile_size_q == '0) ? tsize_t'(1) : tile_size_q;

	assign col_s     = coord_t'(tile_col_q);
	assign row_s     = coord_t'(tile_row_q);
	assign wr_out    = (col_s < 0) || (row_s < 0) || (col_s >= cols_c) || (row_s >= rows_c);
	assign box_empty = (box_width_q == '0) || (box_height_q == '0);

	assign dividend[LANE_X0] = coord_t'(box_x_q);
	assign dividend[LANE_X1] = coord_t'(box_x_q) + coord_t'(box_width_q) - coord_t'(1);
	assign dividend[LANE_Y0] = coord_t'(box_y_q);
	assign dividend[LANE_Y1] = coord_t'(box_y_q) + coord_t'(box_height_q) - coord_t'(1);

	assign div_ctl.start   = (state_q == ST_DEC) && (func_q == FUNC_QUERY) && !box_empty;
	assign div_ctl.divisor = ts_eff;

	tgbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.quotient (quotient),
		.done     (div_done)
	);

	assign q_x0  = quotient[LANE_X0];
	assign q_x1  = quotient[LANE_X1];
	assign q_y0  = quotient[LANE_Y0];
	assign q_y1  = quotient[LANE_Y1];
	assign q_out = (q_x0 < 0) || (q_y0 < 0) || (q_x1 >= cols_c) || (q_y1 >= rows_c);

	assign mul_a    = (state_q == ST_DEC) ? row_s[RW-1:0] : q_y0[RW-1:0];
	assign mul_full = mul_a * eff_cols;

	assign rd_addr    = base_q + AW'(tx_q);
	assign wr_addr    = base_q + AW'(col_s[CW-1:0]);
	assign at_row_end = (tx_q == x1_q);
	assign at_end     = at_row_end && (ty_q == y1_q);
	assign rd_issue   = (state_q == ST_WALK) && !(rd_pend_q && ram_rdata) && !last_q;
	assign slot_free  = !out_valid_q || !out_stall;

	assign ram_we    = (state_q == ST_CLR) || (state_q == ST_WR);
	assign ram_waddr = (state_q == ST_CLR) ? clr_addr_q : wr_addr;
	assign ram_wdata = (state_q == ST_WR) && (tile_value_q == 8'd1);

	tgbc_tile_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		res_load  = 1'b0;
		res_hit_d = 1'b0;
		res_ign_d = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DEC;
				end
			end
			ST_DEC: begin
				if (func_q == FUNC_WRITE) begin
					if (wr_out) begin
						res_load  = 1'b1;
						res_ign_d = 1'b1;
						state_nxt = ST_DONE;
					end else begin
						state_nxt = ST_WR;
					end
				end else if (box_empty) begin
					res_load  = 1'b1;
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_DIV;
				end
			end
			ST_WR: begin
				res_load  = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_CHK;
				end
			end
			ST_CHK: begin
				if (q_out) begin
					res_load  = 1'b1;
					res_hit_d = 1'b1;
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (rd_pend_q && ram_rdata) begin
					res_load  = 1'b1;
					res_hit_d = 1'b1;
					state_nxt = ST_DONE;
				end else if (last_q) begin
					res_load  = 1'b1;
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			rd_pend_q   <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			grid_cols_q <= 7'd64;
			grid_rows_q <= 7'd64;
			tile_size_q <= 9'd16;
		end else begin
			state_q   <= state_nxt;
			rd_pend_q <= rd_issue;
			last_q    <= rd_issue && at_end;
			if (state_q == ST_CLR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GRID_COLS: grid_cols_q <= cfg_data[6:0];
					CFG_GRID_ROWS: grid_rows_q <= cfg_data[6:0];
					CFG_TILE_SIZE: tile_size_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			func_q       <= func;
			tile_col_q   <= tile_col;
			tile_row_q   <= tile_row;
			tile_value_q <= tile_value;
			box_x_q      <= box_x;
			box_y_q      <= box_y;
			box_width_q  <= box_width;
			box_height_q <= box_height;
		end
		if ((state_q == ST_DEC) || (state_q == ST_CHK)) begin
			base_q <= mul_full[AW-1:0];
			tx_q   <= q_x0[CW-1:0];
			ty_q   <= q_y0[RW-1:0];
			x0_q   <= q_x0[CW-1:0];
			x1_q   <= q_x1[CW-1:0];
			y1_q   <= q_y1[RW-1:0];
		end else if (rd_issue && !at_end) begin
			if (at_row_end) begin
				tx_q   <= x0_q;
				ty_q   <= ty_q + 1'b1;
				base_q <= base_q + AW'(eff_cols);
			end else begin
				tx_q <= tx_q + 1'b1;
			end
		end
		if (res_load) begin
			res_hit_q <= res_hit_d;
			res_ign_q <= res_ign_d;
		end
		if ((state_q == ST_DONE) && slot_free) begin
			hit_q <= res_hit_q;
			ign_q <= res_ign_q;
		end
	end

	assign cfg_ready     = 1'b1;
	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign write_ignored = ign_q;

`ifndef SYNTHESIS
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && ign_q))
		else $error("hit and write_ignored both set");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (32'(rd_addr) < 32'(DEPTH)))
		else $error("tile read address beyond map");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (32'(wr_addr) < 32'(DEPTH)))
		else $error("tile write address beyond map");

	a_walk_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((tx_q >= x0_q) && (tx_q <= x1_q) && (ty_q <= y1_q)))
		else $error("walk left the tile bounds");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside completion");
`endif

endmodule

`default_nettype wire
